@@ src/ffa_pkg.sv @@
`default_nettype none

package ffa_pkg;

    // Heap geometry. The heap size also fixes the width of the address fields.
    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 8;

    // Field widths of the command and result words.
    localparam int ADDR_W = $clog2(HEAP_BYTES_DEF);
    localparam int REQ_W  = ADDR_W + 1;
    localparam int STAT_W = 3;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOMEM  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADPTR = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DOUBLE = 3'd4;

    typedef struct packed {
        logic              cmd;
        logic [REQ_W-1:0]  req_size;
        logic [ADDR_W-1:0] free_addr;
    } t_cmd_word;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_addr;
        logic [STAT_W-1:0] status;
    } t_result_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ISSUE,
        S_EVAL,
        S_SPLIT,
        S_NXT,
        S_FWR,
        S_FPREV
    } t_state;

endpackage

`default_nettype wire

@@ src/ffa_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ffa_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/first_fit_heap_allocator.sv @@
`default_nettype none

// Channel   Handshake          Word                 Direction
// -------   -----------------  -------------------  ---------
// command   start / busy       i_cmd_word           in
// result    o_done (strobe)    o_result             out
//
// A zero-size allocate is answered from S_ISSUE without a RAM read; any other
// command reads one chunk header from the RAM for each header visited, a split
// adds S_SPLIT and a successful free adds S_FWR, with S_NXT and S_FPREV as
// needed. The first command after reset also passes S_INIT to build the heap.
// o_done marks o_result for one cycle; the receiver cannot stall, and a new
// command may be taken in that cycle. Reset is synchronous, active low.

module first_fit_heap_allocator #(
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire ffa_pkg::t_cmd_word   i_cmd_word,
    output logic                      o_done,
    output ffa_pkg::t_result_word     o_result
);

    // The heap size is tied to the address field width in the package.
    localparam int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF;

    // Chunk offsets index the header RAM; sizes and offset sums need one
    // more bit so that the full heap size and the end of the heap fit.
    localparam int OFF_W  = $clog2(HEAP_BYTES);
    localparam int SIZE_W = OFF_W + 1;
    localparam int SUM_W  = OFF_W + 1;
    localparam int NEED_W = ffa_pkg::REQ_W + 1;
    localparam int CMP_W  = (SIZE_W > NEED_W) ? SIZE_W : NEED_W;
    localparam int HDR_WW = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] HEAP_SZ  = SIZE_W'(HEAP_BYTES);
    localparam logic [SUM_W-1:0]  HEAP_END = SUM_W'(HEAP_BYTES);
    localparam logic [CMP_W-1:0]  HDR_C    = CMP_W'(HEADER_BYTES);

    // Control state.
    ffa_pkg::t_state       r_state, n_state;
    logic                  r_ready, n_ready;
    logic                  r_done,  n_done;

    // Working registers of the chain walk.
    ffa_pkg::t_cmd_word    r_in,      n_in;
    logic [SUM_W-1:0]      r_off,     n_off;
    logic [SIZE_W-1:0]     r_size,    n_size;
    logic [OFF_W-1:0]      r_prev,    n_prev;
    logic [SIZE_W-1:0]     r_prev_sz, n_prev_sz;
    logic                  r_prev_used, n_prev_used;
    logic                  r_have_prev, n_have_prev;
    ffa_pkg::t_result_word r_out,     n_out;

    // Header RAM port signals.
    logic                  wr_en;
    logic [OFF_W-1:0]      wr_addr;
    logic [HDR_WW-1:0]     wr_data;
    logic                  rd_en;
    logic [OFF_W-1:0]      rd_addr;
    logic [HDR_WW-1:0]     rd_data;
    logic                  rd_used;
    logic [SIZE_W-1:0]     rd_size;

    // The one shared adder: steps along the chain, forms the split address
    // and sums chunk sizes when merging.
    logic [SUM_W-1:0]      add_a, add_b, sum;

    // Compare operands, widened to CMP_W, used in evaluating a header and the split.
    logic [CMP_W-1:0]      need_c, sz_c, rest_c, off_hc, faddr_c;

    ffa_ram #(
        .WIDTH (HDR_WW),
        .DEPTH (HEAP_BYTES)
    ) u_hdr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_used = rd_data[SIZE_W];
    assign rd_size = rd_data[SIZE_W-1:0];

    assign sum     = add_a + add_b;
    assign need_c  = CMP_W'(r_in.req_size) + HDR_C;
    assign sz_c    = CMP_W'(rd_size);
    assign rest_c  = sz_c - need_c;
    assign off_hc  = CMP_W'(r_off) + HDR_C;
    assign faddr_c = CMP_W'(r_in.free_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::S_IDLE;
            r_ready <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_done  <= n_done;
        end
        r_in        <= n_in;
        r_off       <= n_off;
        r_size      <= n_size;
        r_prev      <= n_prev;
        r_prev_sz   <= n_prev_sz;
        r_prev_used <= n_prev_used;
        r_have_prev <= n_have_prev;
        r_out       <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_ready     = r_ready;
        n_done      = 1'b0;
        n_in        = r_in;
        n_off       = r_off;
        n_size      = r_size;
        n_prev      = r_prev;
        n_prev_sz   = r_prev_sz;
        n_prev_used = r_prev_used;
        n_have_prev = r_have_prev;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        add_a       = '0;
        add_b       = '0;

        case (r_state)
            ffa_pkg::S_IDLE: begin
                if (start) begin
                    n_in        = i_cmd_word;
                    n_off       = '0;
                    n_have_prev = 1'b0;
                    n_state     = r_ready ? ffa_pkg::S_ISSUE : ffa_pkg::S_INIT;
                end
            end

            // First command after reset: the whole heap becomes one free chunk.
            ffa_pkg::S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {1'b0, HEAP_SZ};
                n_ready = 1'b1;
                n_state = ffa_pkg::S_ISSUE;
            end

            ffa_pkg::S_ISSUE: begin
                if (r_in.cmd == ffa_pkg::CMD_ALLOC && r_in.req_size == '0) begin
                    n_out.payload_addr = '0;
                    n_out.status       = ffa_pkg::STAT_ZERO;
                    n_done             = 1'b1;
                    n_state            = ffa_pkg::S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_state = ffa_pkg::S_EVAL;
                end
            end

            // The header at r_off is on the read port. The adder gives the
            // offset of the following chunk, whose read is started at once
            // when the walk goes on.
            ffa_pkg::S_EVAL: begin
                add_a = r_off;
                add_b = SUM_W'(rd_size);
                if (r_in.cmd == ffa_pkg::CMD_ALLOC) begin
                    if (rd_size == '0) begin
                        n_out.payload_addr = '0;
                        n_out.status       = ffa_pkg::STAT_NOMEM;
                        n_done             = 1'b1;
                        n_state            = ffa_pkg::S_IDLE;
                    end else if (!rd_used && sz_c >= need_c) begin
                        wr_en   = 1'b1;
                        wr_addr = r_off[OFF_W-1:0];
                        if (rest_c > HDR_C) begin
                            // Split: shrink this chunk, the tail follows.
                            wr_data = {1'b1, SIZE_W'(need_c)};
                            n_size  = SIZE_W'(rest_c);
                            n_state = ffa_pkg::S_SPLIT;
                        end else begin
                            wr_data            = {1'b1, rd_size};
                            n_out.payload_addr = ffa_pkg::ADDR_W'(off_hc);
                            n_out.status       = ffa_pkg::STAT_OK;
                            n_done             = 1'b1;
                            n_state            = ffa_pkg::S_IDLE;
                        end
                    end else if (sum < HEAP_END) begin
                        n_off   = sum;
                        rd_en   = 1'b1;
                        rd_addr = sum[OFF_W-1:0];
                    end else begin
                        n_out.payload_addr = '0;
                        n_out.status       = ffa_pkg::STAT_NOMEM;
                        n_done             = 1'b1;
                        n_state            = ffa_pkg::S_IDLE;
                    end
                end else begin
                    if (rd_size == '0) begin
                        n_out.payload_addr = '0;
                        n_out.status       = ffa_pkg::STAT_BADPTR;
                        n_done             = 1'b1;
                        n_state            = ffa_pkg::S_IDLE;
                    end else if (off_hc == faddr_c) begin
                        if (!rd_used) begin
                            n_out.payload_addr = '0;
                            n_out.status       = ffa_pkg::STAT_DOUBLE;
                            n_done             = 1'b1;
                            n_state            = ffa_pkg::S_IDLE;
                        end else begin
                            n_size = rd_size;
                            if (sum < HEAP_END) begin
                                // Fetch the successor to see if it merges.
                                rd_en   = 1'b1;
                                rd_addr = sum[OFF_W-1:0];
                                n_state = ffa_pkg::S_NXT;
                            end else begin
                                n_state = ffa_pkg::S_FWR;
                            end
                        end
                    end else if (off_hc > faddr_c) begin
                        // Walked past the address: it is not a payload start.
                        n_out.payload_addr = '0;
                        n_out.status       = ffa_pkg::STAT_BADPTR;
                        n_done             = 1'b1;
                        n_state            = ffa_pkg::S_IDLE;
                    end else if (sum < HEAP_END) begin
                        n_prev      = r_off[OFF_W-1:0];
                        n_prev_sz   = rd_size;
                        n_prev_used = rd_used;
                        n_have_prev = 1'b1;
                        n_off       = sum;
                        rd_en       = 1'b1;
                        rd_addr     = sum[OFF_W-1:0];
                    end else begin
                        n_out.payload_addr = '0;
                        n_out.status       = ffa_pkg::STAT_BADPTR;
                        n_done             = 1'b1;
                        n_state            = ffa_pkg::S_IDLE;
                    end
                end
            end

            // Write the free tail that was split off the granted chunk.
            ffa_pkg::S_SPLIT: begin
                add_a              = r_off;
                add_b              = SUM_W'(need_c);
                wr_en              = 1'b1;
                wr_addr            = sum[OFF_W-1:0];
                wr_data            = {1'b0, r_size};
                n_out.payload_addr = ffa_pkg::ADDR_W'(off_hc);
                n_out.status       = ffa_pkg::STAT_OK;
                n_done             = 1'b1;
                n_state            = ffa_pkg::S_IDLE;
            end

            // Successor header is on the read port; absorb it if free.
            ffa_pkg::S_NXT: begin
                add_a = r_size;
                add_b = SUM_W'(rd_size);
                if (!rd_used) begin
                    n_size = SIZE_W'(sum);
                end
                n_state = ffa_pkg::S_FWR;
            end

            ffa_pkg::S_FWR: begin
                wr_en   = 1'b1;
                wr_addr = r_off[OFF_W-1:0];
                wr_data = {1'b0, r_size};
                if (r_have_prev && !r_prev_used) begin
                    n_state = ffa_pkg::S_FPREV;
                end else begin
                    n_out.payload_addr = '0;
                    n_out.status       = ffa_pkg::STAT_OK;
                    n_done             = 1'b1;
                    n_state            = ffa_pkg::S_IDLE;
                end
            end

            // The free predecessor swallows the freed chunk.
            ffa_pkg::S_FPREV: begin
                add_a              = SUM_W'(r_prev_sz);
                add_b              = SUM_W'(r_size);
                wr_en              = 1'b1;
                wr_addr            = r_prev;
                wr_data            = {1'b0, SIZE_W'(sum)};
                n_out.payload_addr = '0;
                n_out.status       = ffa_pkg::STAT_OK;
                n_done             = 1'b1;
                n_state            = ffa_pkg::S_IDLE;
            end

            default: begin
                n_state = ffa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ffa_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    // A result is only presented once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted command always starts work.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but sequencer stayed idle");

    // Every command passes S_ISSUE before its result, so strobes never touch.
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back to back result strobes");

    // Only a successful allocate hands out a nonzero address.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ffa_pkg::STAT_OK) |-> (o_result.payload_addr == '0))
        else $error("address given with an error status");

endmodule

`default_nettype wire

@@ tb/first_fit_heap_allocator_tb.sv @@
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;

    localparam int HEAP = ffa_pkg::HEAP_BYTES_DEF;
    localparam int HDR  = ffa_pkg::HEADER_BYTES_DEF;

    // Design interface. Every input has a known value from time zero.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    ffa_pkg::t_cmd_word    cmd_word = '0;
    logic                  o_done;
    ffa_pkg::t_result_word o_result;

    first_fit_heap_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd_word (cmd_word),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // Shadow heap: the size and in-use mark of the chunk header at each byte
    // offset. Only offsets on the chain are ever looked at, and each of those
    // has been written since the shadow heap was brought up.
    int unsigned  chunk_size [HEAP];
    bit           chunk_used [HEAP];
    bit           heap_up = 1'b0;

    // Result words predicted for accepted commands, oldest first.
    ffa_pkg::t_result_word predicted_results[$];

    // Payload offsets that are currently handed out, as the shadow heap sees them.
    int unsigned  live_addrs[$];
    // A few recently released offsets, used to provoke double frees.
    int unsigned  released_addrs[$];

    // Percentage of command slots after which the sender pauses.
    int unsigned  idle_pct = 0;
    int unsigned  err_cnt = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the design hangs with busy high or never answers.
    initial begin
        #6_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic flag_error(input string what);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    // Applies one command word to the shadow heap and returns the result word
    // the design must produce for it.
    function automatic ffa_pkg::t_result_word heap_apply(input ffa_pkg::t_cmd_word w);
        ffa_pkg::t_result_word r;
        int unsigned  off;
        int unsigned  sz;
        int unsigned  need;
        int unsigned  rest;
        int unsigned  nxt;
        int unsigned  prev;
        int unsigned  target;
        bit           have_prev;
        bit           walk_done;

        r.payload_addr = '0;
        off = 0;
        prev = 0;
        have_prev = 1'b0;
        walk_done = 1'b0;

        // Any first command turns the whole heap into one free chunk.
        if (!heap_up) begin
            chunk_size[0] = HEAP;
            chunk_used[0] = 1'b0;
            heap_up = 1'b1;
        end

        if (w.cmd == ffa_pkg::CMD_ALLOC) begin
            need = w.req_size + HDR;
            r.status = ffa_pkg::STAT_NOMEM;
            if (w.req_size == 0) begin
                r.status = ffa_pkg::STAT_ZERO;
                walk_done = 1'b1;
            end
            while (!walk_done && off < HEAP) begin
                sz = chunk_size[off];
                if (sz == 0) begin
                    walk_done = 1'b1;
                end else if (!chunk_used[off] && sz >= need) begin
                    // Split only when the leftover can carry a header and at
                    // least one payload byte; otherwise grant the whole chunk.
                    rest = sz - need;
                    if (rest > HDR) begin
                        chunk_size[off + need] = rest;
                        chunk_used[off + need] = 1'b0;
                        chunk_size[off] = need;
                    end
                    chunk_used[off] = 1'b1;
                    r.payload_addr = ffa_pkg::ADDR_W'(off + HDR);
                    r.status = ffa_pkg::STAT_OK;
                    walk_done = 1'b1;
                end else begin
                    off += sz;
                end
            end
        end else begin
            target = w.free_addr;
            r.status = ffa_pkg::STAT_BADPTR;
            while (!walk_done && off < HEAP) begin
                sz = chunk_size[off];
                if (sz == 0) begin
                    walk_done = 1'b1;
                end else if (off + HDR == target) begin
                    if (!chunk_used[off]) begin
                        r.status = ffa_pkg::STAT_DOUBLE;
                    end else begin
                        // Release, then fold in a free successor and let a
                        // free predecessor absorb the result.
                        chunk_used[off] = 1'b0;
                        nxt = off + sz;
                        if (nxt < HEAP && !chunk_used[nxt]) begin
                            chunk_size[off] += chunk_size[nxt];
                        end
                        if (have_prev && !chunk_used[prev]) begin
                            chunk_size[prev] += chunk_size[off];
                        end
                        r.status = ffa_pkg::STAT_OK;
                    end
                    walk_done = 1'b1;
                end else if (off + HDR > target) begin
                    walk_done = 1'b1;
                end else begin
                    prev = off;
                    have_prev = 1'b1;
                    off += sz;
                end
            end
        end
        return r;
    endfunction

    function automatic ffa_pkg::t_cmd_word alloc_word(input int unsigned bytes);
        ffa_pkg::t_cmd_word w;
        w.cmd = ffa_pkg::CMD_ALLOC;
        w.req_size = ffa_pkg::REQ_W'(bytes);
        w.free_addr = ffa_pkg::ADDR_W'($urandom());
        return w;
    endfunction

    function automatic ffa_pkg::t_cmd_word free_word(input int unsigned addr);
        ffa_pkg::t_cmd_word w;
        w.cmd = ffa_pkg::CMD_FREE;
        w.req_size = ffa_pkg::REQ_W'($urandom());
        w.free_addr = ffa_pkg::ADDR_W'(addr);
        return w;
    endfunction

    // Offers one command word and holds it until the design takes it. Start is
    // left high on return so that back-to-back words need no second write in
    // the same step; a pause, when one is drawn, lowers it first.
    task automatic send_word(input ffa_pkg::t_cmd_word w);
        ffa_pkg::t_result_word r;
        int           idx[$];

        start <= 1'b1;
        cmd_word <= w;
        do begin
            @(posedge i_clk);
        end while (busy);

        r = heap_apply(w);
        predicted_results.push_back(r);

        // Track which payload offsets are out, for the random traffic.
        if (r.status == ffa_pkg::STAT_OK) begin
            if (w.cmd == ffa_pkg::CMD_ALLOC) begin
                live_addrs.push_back(r.payload_addr);
            end else begin
                idx = live_addrs.find_first_index(a) with (a == w.free_addr);
                if (idx.size() != 0) begin
                    live_addrs.delete(idx[0]);
                end
                released_addrs.push_back(w.free_addr);
                if (released_addrs.size() > 8) begin
                    void'(released_addrs.pop_front());
                end
            end
        end

        if ($urandom_range(99) < idle_pct) begin
            // Junk on the command bus while start is low must be ignored.
            start <= 1'b0;
            cmd_word <= ffa_pkg::t_cmd_word'($urandom());
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // Every result strobe must match the oldest outstanding prediction.
    always @(posedge i_clk) begin
        ffa_pkg::t_result_word want;
        if (i_rst_n && o_done) begin
            if (predicted_results.size() == 0) begin
                flag_error($sformatf("unexpected result: addr %0d status %0d",
                                     o_result.payload_addr, o_result.status));
            end else begin
                want = predicted_results.pop_front();
                if (o_result.payload_addr !== want.payload_addr ||
                    o_result.status !== want.status) begin
                    flag_error($sformatf(
                        "result mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                        want.payload_addr, want.status,
                        o_result.payload_addr, o_result.status));
                end
            end
        end
    end

    // The very first command also brings the heap up, so a free here sees one
    // big free chunk: its own payload offset is a double free, anything else
    // is an unknown pointer.
    task automatic test_free_before_alloc();
        send_word(free_word(HDR));
        send_word(free_word(0));
    endtask

    // Zero size, requests too big by one byte or more, and an exact fit that
    // takes the whole heap with nothing left over.
    task automatic test_alloc_limits();
        send_word(alloc_word(0));
        send_word(alloc_word(HEAP));
        send_word(alloc_word(HEAP - HDR + 1));
        send_word(alloc_word(HEAP - HDR));
        send_word(alloc_word(1));
        send_word(free_word(HDR));
        send_word(free_word(HDR));
    endtask

    // Leftover of header plus one byte is split off and then filled exactly,
    // which puts a payload at the last byte offset; a leftover of just a
    // header is not split and goes with the grant.
    task automatic test_split_rules();
        send_word(alloc_word(HEAP - 2 * HDR - 1));
        send_word(alloc_word(1));
        send_word(free_word(HEAP - 1));
        send_word(free_word(HDR));
        send_word(alloc_word(HEAP - 2 * HDR));
        send_word(free_word(HDR));
    endtask

    // Four neighbors, freed so that every merge direction comes up: successor
    // only, predecessor only, and both at once. An offset inside a chunk is
    // not a payload offset.
    task automatic test_merges();
        repeat (4) send_word(alloc_word(16));
        send_word(free_word(HDR + 12));
        send_word(free_word(HDR + 24));
        send_word(free_word(HDR));
        send_word(free_word(HDR + 48));
        send_word(free_word(HDR + 72));
    endtask

    // Mostly well-formed traffic: allocations of mixed sizes and frees of
    // offsets that are out, with double frees, random pointers and the odd
    // zero-size or oversized request mixed in.
    task automatic test_random_traffic(input int unsigned n, input int unsigned pct);
        int unsigned pick;
        int unsigned alloc_pct;
        int unsigned bytes;

        idle_pct = pct;
        repeat (n) begin
            alloc_pct = (live_addrs.size() > 48) ? 30 : 55;
            if (live_addrs.size() == 0) begin
                alloc_pct = 90;
            end
            if ($urandom_range(99) < alloc_pct) begin
                pick = $urandom_range(99);
                if (pick < 2) begin
                    bytes = 0;
                end else if (pick < 72) begin
                    bytes = $urandom_range(1, 64);
                end else if (pick < 92) begin
                    bytes = $urandom_range(65, 512);
                end else begin
                    bytes = $urandom_range(513, HEAP);
                end
                send_word(alloc_word(bytes));
            end else begin
                pick = $urandom_range(99);
                if (pick < 80 && live_addrs.size() != 0) begin
                    send_word(free_word(live_addrs[$urandom_range(live_addrs.size() - 1)]));
                end else if (pick < 90 && released_addrs.size() != 0) begin
                    send_word(free_word(
                        released_addrs[$urandom_range(released_addrs.size() - 1)]));
                end else begin
                    send_word(free_word($urandom_range(HEAP - 1)));
                end
            end
        end
    endtask

    initial begin
        int unsigned guard;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_free_before_alloc();
        test_alloc_limits();
        test_split_rules();
        test_merges();

        // Back-to-back words, then heavily and moderately gappy sending, then back-to-back again.
        test_random_traffic(350, 0);
        test_random_traffic(350, 53);
        test_random_traffic(350, 37);
        test_random_traffic(350, 0);
        start <= 1'b0;

        // Drain, then keep the clock running so that any stray result shows.
        guard = 0;
        while (predicted_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
        if (predicted_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", predicted_results.size()));
        end

        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ first_fit_heap_allocator.f @@
src/ffa_pkg.sv
src/ffa_ram.sv
src/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_tb.sv
